// ----- rtl/assoc_cache_fifo_writeback_defines.svh -----
// Assertion macros shared by the cache RTL.
`ifndef ASSOC_CACHE_FIFO_WRITEBACK_DEFINES_SVH
`define ASSOC_CACHE_FIFO_WRITEBACK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACFW_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACFW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/acfw_pkg.sv -----
// Shared types and constants of the write-back cache.
package acfw_pkg;

   localparam int MEM_WORDS_DEF     = 64;
   localparam int CACHE_ENTRIES_DEF = 8;
   localparam int DATA_BITS_DEF     = 32;

   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int LIMIT_BITS  = 4;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd5;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_READ        = 2'd0,
      KIND_WRITE       = 2'd1,
      KIND_CLEAR_CACHE = 2'd2,
      KIND_CLEAR_MEM   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_HIT   = 3'd0,
      ST_FILL  = 3'd1,
      ST_NONE  = 3'd2,
      ST_MEM   = 3'd3,
      ST_CLEAR = 3'd4
   } status_type;

   // Directory command from the controller.
   typedef struct packed {
      logic clear;
      logic alloc;
   } dir_cmd_type;

   // Directory lookup flags.
   typedef struct packed {
      logic hit;
      logic full;
   } dir_look_type;

endpackage

// ----- rtl/acfw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module acfw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/acfw_dir.sv -----
// Cache directory: entry tags, valid bits and insertion ages, with lookup and allocation.
module acfw_dir #(
   parameter int CACHE_ENTRIES = 8,
   parameter int TAG_BITS = 6,
   parameter int IDX_BITS = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  acfw_pkg::dir_cmd_type                cmd,
   input  logic [TAG_BITS-1:0]                  tag,
   input  logic [acfw_pkg::LIMIT_BITS-1:0]      limit,
   output acfw_pkg::dir_look_type               look,
   output logic [IDX_BITS-1:0]                  hit_idx,
   output logic [IDX_BITS-1:0]                  old_idx,
   output logic [TAG_BITS-1:0]                  old_tag,
   output logic [IDX_BITS-1:0]                  slot_idx
);
   import acfw_pkg::*;

   localparam int CNT_BITS = $clog2(CACHE_ENTRIES + 1);
   localparam int CMP_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TAG_BITS-1:0]      tag_ff [CACHE_ENTRIES];
   logic [TAG_BITS-1:0]      tag_in [CACHE_ENTRIES];
   logic [IDX_BITS-1:0]      age_ff [CACHE_ENTRIES];
   logic [IDX_BITS-1:0]      age_in [CACHE_ENTRIES];

   logic [CNT_BITS-1:0]      used;
   logic [IDX_BITS-1:0]      last_age;
   logic [CMP_BITS-1:0]      eff_limit;
   logic [CACHE_ENTRIES-1:0] hit_vec, old_vec, keep;
   logic                     full;

   // Valid ages are always 0 .. used-1, so the oldest entry has age used-1.
   always_comb begin
      used     = CNT_BITS'($countones(valid_ff));
      last_age = IDX_BITS'(used - CNT_BITS'(1));
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (tag_ff[i] == tag);
         old_vec[i] = valid_ff[i] && (age_ff[i] == last_age);
      end
      hit_idx = '0;
      old_idx = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_BITS'(i);
         end
         if (old_vec[i]) begin
            old_idx = IDX_BITS'(i);
         end
      end
      if (limit == '0) begin
         eff_limit = CMP_BITS'(1);
      end else if (CMP_BITS'(limit) > CMP_BITS'(CACHE_ENTRIES)) begin
         eff_limit = CMP_BITS'(CACHE_ENTRIES);
      end else begin
         eff_limit = CMP_BITS'(limit);
      end
      full = CMP_BITS'(used) >= eff_limit;
      keep = valid_ff & ~(full ? old_vec : '0);
      slot_idx = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (!keep[i]) begin
            slot_idx = IDX_BITS'(i);
         end
      end
      old_tag   = tag_ff[old_idx];
      look.hit  = |hit_vec;
      look.full = full;
   end

   // Clear drops all; alloc evicts oldest if full, ages the rest, takes first free slot.
   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      age_in   = age_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.alloc) begin
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (IDX_BITS'(i) == slot_idx) begin
               valid_in[i] = 1'b1;
               tag_in[i]   = tag;
               age_in[i]   = '0;
            end else begin
               valid_in[i] = keep[i];
               if (keep[i]) begin
                  age_in[i] = age_ff[i] + IDX_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      age_ff <= age_in;
   end

endmodule

// ----- rtl/assoc_cache_fifo_writeback.sv -----
// Top level of the fully associative write-back cache with oldest-first replacement.
// Usage:
//  - req_* carries one request (read, write, clear cache, clear memory) with
//    valid/ready; rsp_* returns exactly one response per request, in order.
//  - csr_cache_limit sets how many entries fill before eviction; a write drops
//    all entries without writeback. csr_ready is always high; write only idle.
//  - Requests that need no RAM read (clears, write hit, direct memory write, not
//    found) go from S_LOOKUP to S_FINISH; read hit, fill and write allocation
//    pass through S_ACCESS, which takes the entry or word RAM read data and
//    writes back the evicted entry, if any, for fill and allocation.
//  - One request is in work at a time; req_ready is high only in S_IDLE, so the
//    next one waits out the lookup, RAM read and write-back sequence.
//  - The response sits in an output register; the next request is taken while
//    it waits. If a second response is ready before the first is taken, the
//    controller holds it until rsp_ready and accepts nothing meanwhile.
//  - Reset: all entries invalid, every memory word empty, cache_limit = 5.
//    No clearing pass is needed; word contents are read only once written.
`include "assoc_cache_fifo_writeback_defines.svh"
module assoc_cache_fifo_writeback #(
   parameter int MEM_WORDS     = acfw_pkg::MEM_WORDS_DEF,
   parameter int CACHE_ENTRIES = acfw_pkg::CACHE_ENTRIES_DEF,
   parameter int DATA_BITS     = acfw_pkg::DATA_BITS_DEF,
   parameter int ADDR_BITS     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [acfw_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [ADDR_BITS-1:0]                req_address,
   input  logic [DATA_BITS-1:0]                req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [DATA_BITS-1:0]                rsp_read_data,
   output logic [acfw_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                                rsp_evicted,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acfw_pkg::LIMIT_BITS-1:0]     csr_cache_limit
);
   import acfw_pkg::*;

   localparam int IDX_BITS = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_ACCESS,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_RD_HIT,
      OP_FILL,
      OP_ALLOC_WR
   } op_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   kind_type               kind_ff, kind_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [DATA_BITS-1:0]   wdata_ff, wdata_in;
   logic                   evict_ff, evict_in;
   logic [ADDR_BITS-1:0]   evict_tag_ff, evict_tag_in;
   logic [IDX_BITS-1:0]    slot_ff, slot_in;
   logic [DATA_BITS-1:0]   res_data_ff, res_data_in;
   status_type             res_status_ff, res_status_in;
   logic                   res_evict_ff, res_evict_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;
   logic [LIMIT_BITS-1:0]  limit_ff, limit_in;
   logic [MEM_WORDS-1:0]   present_ff, present_in;

   dir_cmd_type            dir_cmd;
   dir_look_type           dir_look;
   logic [IDX_BITS-1:0]    hit_idx, old_idx, slot_idx;
   logic [ADDR_BITS-1:0]   old_tag;

   logic                   ent_wr_en;
   logic [IDX_BITS-1:0]    ent_wr_addr, ent_rd_addr;
   logic [DATA_BITS-1:0]   ent_wr_data, ent_rd_data;
   logic                   wrd_wr_en;
   logic [ADDR_BITS-1:0]   wrd_wr_addr;
   logic [DATA_BITS-1:0]   wrd_wr_data, wrd_rd_data;

   logic                   req_take, csr_take, in_range, present_hit;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign in_range  = int'(addr_ff) < MEM_WORDS;
   assign present_hit = present_ff[addr_ff];

   acfw_dir #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .TAG_BITS      (ADDR_BITS),
      .IDX_BITS      (IDX_BITS)
   ) u_dir (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dir_cmd),
      .tag      (addr_ff),
      .limit    (limit_ff),
      .look     (dir_look),
      .hit_idx  (hit_idx),
      .old_idx  (old_idx),
      .old_tag  (old_tag),
      .slot_idx (slot_idx)
   );

   acfw_ram #(
      .WIDTH     (DATA_BITS),
      .DEPTH     (CACHE_ENTRIES),
      .ADDR_BITS (IDX_BITS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   acfw_ram #(
      .WIDTH     (DATA_BITS),
      .DEPTH     (MEM_WORDS),
      .ADDR_BITS (ADDR_BITS)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (wrd_wr_en),
      .wr_addr (wrd_wr_addr),
      .wr_data (wrd_wr_data),
      .rd_addr (addr_ff),
      .rd_data (wrd_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      kind_in        = kind_ff;
      addr_in        = addr_ff;
      wdata_in       = wdata_ff;
      evict_in       = evict_ff;
      evict_tag_in   = evict_tag_ff;
      slot_in        = slot_ff;
      res_data_in    = res_data_ff;
      res_status_in  = res_status_ff;
      res_evict_in   = res_evict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_evicted_in = rsp_evicted_ff;
      limit_in       = limit_ff;
      present_in     = present_ff;
      dir_cmd.clear  = csr_take;
      dir_cmd.alloc  = 1'b0;
      ent_wr_en      = 1'b0;
      ent_wr_addr    = hit_idx;
      ent_wr_data    = wdata_ff;
      ent_rd_addr    = dir_look.hit ? hit_idx : old_idx;
      wrd_wr_en      = 1'b0;
      wrd_wr_addr    = addr_ff;
      wrd_wr_data    = wdata_ff;

      if (csr_take) begin
         limit_in = csr_cache_limit;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               kind_in  = kind_type'(req_kind);
               addr_in  = req_address;
               wdata_in = req_write_data;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            res_data_in   = '0;
            res_evict_in  = 1'b0;
            res_status_in = ST_NONE;
            evict_in      = dir_look.full;
            evict_tag_in  = old_tag;
            slot_in       = slot_idx;
            state_in      = S_FINISH;
            case (kind_ff)
               KIND_CLEAR_CACHE: begin
                  dir_cmd.clear = 1'b1;
                  res_status_in = ST_CLEAR;
               end
               KIND_CLEAR_MEM: begin
                  present_in    = '0;
                  res_status_in = ST_CLEAR;
               end
               KIND_READ: begin
                  if (!in_range) begin
                     res_status_in = ST_NONE;
                  end else if (dir_look.hit) begin
                     op_in    = OP_RD_HIT;
                     state_in = S_ACCESS;
                  end else if (present_hit) begin
                     dir_cmd.alloc = 1'b1;
                     op_in         = OP_FILL;
                     state_in      = S_ACCESS;
                  end
               end
               KIND_WRITE: begin
                  if (!in_range) begin
                     res_status_in = ST_NONE;
                  end else if (dir_look.hit) begin
                     ent_wr_en     = 1'b1;
                     res_status_in = ST_HIT;
                  end else if (present_hit) begin
                     dir_cmd.alloc = 1'b1;
                     op_in         = OP_ALLOC_WR;
                     state_in      = S_ACCESS;
                  end else begin
                     wrd_wr_en           = 1'b1;
                     present_in[addr_ff] = 1'b1;
                     res_status_in       = ST_MEM;
                  end
               end
               default: begin
                  res_status_in = ST_NONE;
               end
            endcase
         end
         S_ACCESS: begin
            state_in    = S_FINISH;
            ent_wr_addr = slot_ff;
            // write back the evicted entry read during lookup
            if (op_ff != OP_RD_HIT && evict_ff) begin
               wrd_wr_en                = 1'b1;
               wrd_wr_addr              = evict_tag_ff;
               wrd_wr_data              = ent_rd_data;
               present_in[evict_tag_ff] = 1'b1;
            end
            case (op_ff)
               OP_RD_HIT: begin
                  res_data_in   = ent_rd_data;
                  res_status_in = ST_HIT;
               end
               OP_FILL: begin
                  ent_wr_en     = 1'b1;
                  ent_wr_data   = wrd_rd_data;
                  res_data_in   = wrd_rd_data;
                  res_status_in = ST_FILL;
                  res_evict_in  = evict_ff;
               end
               OP_ALLOC_WR: begin
                  ent_wr_en     = 1'b1;
                  ent_wr_data   = wdata_ff;
                  res_status_in = ST_FILL;
                  res_evict_in  = evict_ff;
               end
               default: begin
                  res_status_in = ST_NONE;
               end
            endcase
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = res_data_ff;
               rsp_status_in  = res_status_ff;
               rsp_evicted_in = res_evict_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         present_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         present_ff   <= present_in;
      end
      op_ff          <= op_in;
      kind_ff        <= kind_in;
      addr_ff        <= addr_in;
      wdata_ff       <= wdata_in;
      evict_ff       <= evict_in;
      evict_tag_ff   <= evict_tag_in;
      slot_ff        <= slot_in;
      res_data_ff    <= res_data_in;
      res_status_ff  <= res_status_in;
      res_evict_ff   <= res_evict_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_evicted   = rsp_evicted_ff;

   `ACFW_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready,
                     "request taken while busy")
   `ACFW_ASSERT_NOW(a_alloc_on_miss, dir_cmd.alloc, !dir_look.hit, "allocation on a hit")
   `ACFW_ASSERT_NOW(a_wb_other_word,
                    state_ff == S_ACCESS && op_ff != OP_RD_HIT && evict_ff,
                    evict_tag_ff != addr_ff, "writeback to requested word")
   `ACFW_ASSERT_NOW(a_evict_is_fill, rsp_valid && rsp_evicted, rsp_status == ST_FILL,
                    "eviction without allocation")

endmodule

// ----- tb/acfw_response_check.sv -----
// Response checker for the write-back cache: predicts every response and compares.
`timescale 1ns / 1ps

module acfw_response_check (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_ready,
   input  logic [acfw_pkg::KIND_BITS-1:0]               req_kind,
   input  logic [$clog2(acfw_pkg::MEM_WORDS_DEF)-1:0]   req_address,
   input  logic [acfw_pkg::DATA_BITS_DEF-1:0]           req_write_data,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   input  logic [acfw_pkg::DATA_BITS_DEF-1:0]           rsp_read_data,
   input  logic [acfw_pkg::STATUS_BITS-1:0]             rsp_status,
   input  logic                                         rsp_evicted,
   input  logic                                         csr_valid,
   input  logic                                         csr_ready,
   input  logic [acfw_pkg::LIMIT_BITS-1:0]              csr_cache_limit,
   output int                                           failures,
   output int                                           pending
);
   import acfw_pkg::*;

   localparam int MEM_WORDS     = MEM_WORDS_DEF;
   localparam int CACHE_ENTRIES = CACHE_ENTRIES_DEF;
   localparam int DATA_BITS     = DATA_BITS_DEF;
   localparam int ADDR_BITS     = $clog2(MEM_WORDS);
   localparam int AGE_BITS      = $clog2(CACHE_ENTRIES);

   typedef struct packed {
      logic [DATA_BITS-1:0] read_data;
      status_type           status;
      logic                 evicted;
   } response_type;

   logic [LIMIT_BITS-1:0] limit_setting;
   logic [ADDR_BITS-1:0]  line_tag   [CACHE_ENTRIES];
   logic [DATA_BITS-1:0]  line_data  [CACHE_ENTRIES];
   logic                  line_valid [CACHE_ENTRIES];
   logic [AGE_BITS-1:0]   line_age   [CACHE_ENTRIES];
   logic [DATA_BITS-1:0]  word_store [MEM_WORDS];
   logic                  word_present [MEM_WORDS];

   response_type expected_responses[$];
   int fail_count = 0;

   function automatic void drop_lines();
      foreach (line_valid[i]) begin
         line_valid[i] = 1'b0;
         line_tag[i]   = '0;
         line_data[i]  = '0;
         line_age[i]   = '0;
      end
   endfunction

   // Insert addr; evict the oldest line first when the active limit is reached.
   function automatic logic allocate_line(logic [ADDR_BITS-1:0] addr,
                                          logic [DATA_BITS-1:0] data);
      int used;
      int lim;
      int oldest;
      int slot;
      logic ev;
      used   = 0;
      oldest = -1;
      slot   = -1;
      ev     = 1'b0;
      if (limit_setting == 0)
         lim = 1;
      else if (limit_setting > CACHE_ENTRIES)
         lim = CACHE_ENTRIES;
      else
         lim = limit_setting;
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (line_valid[i])
            used++;
      if (used >= lim) begin
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (line_valid[i] && (oldest < 0 || line_age[i] > line_age[oldest]))
               oldest = i;
         if (oldest >= 0) begin
            word_store[line_tag[oldest]]   = line_data[oldest];
            word_present[line_tag[oldest]] = 1'b1;
            line_valid[oldest] = 1'b0;
            ev = 1'b1;
         end
      end
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (line_valid[i])
            line_age[i] = line_age[i] + 1'b1;
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (!line_valid[i] && slot < 0)
            slot = i;
      if (slot < 0)
         slot = 0;
      line_valid[slot] = 1'b1;
      line_tag[slot]   = addr;
      line_data[slot]  = data;
      line_age[slot]   = '0;
      return ev;
   endfunction

   function automatic response_type predict_access(kind_type kind,
                                                   logic [ADDR_BITS-1:0] addr,
                                                   logic [DATA_BITS-1:0] wdata);
      response_type r;
      int hit;
      r.read_data = '0;
      r.status    = ST_NONE;
      r.evicted   = 1'b0;
      hit = -1;
      case (kind)
         KIND_CLEAR_CACHE: begin
            drop_lines();
            r.status = ST_CLEAR;
         end
         KIND_CLEAR_MEM: begin
            // cached lines survive a memory clear
            foreach (word_present[i])
               word_present[i] = 1'b0;
            r.status = ST_CLEAR;
         end
         default: begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
               if (hit < 0 && line_valid[i] && line_tag[i] == addr)
                  hit = i;
            if (kind == KIND_READ) begin
               if (hit >= 0) begin
                  r.read_data = line_data[hit];
                  r.status    = ST_HIT;
               end else if (word_present[addr]) begin
                  r.read_data = word_store[addr];
                  r.evicted   = allocate_line(addr, word_store[addr]);
                  r.status    = ST_FILL;
               end
            end else begin
               if (hit >= 0) begin
                  line_data[hit] = wdata;
                  r.status       = ST_HIT;
               end else if (word_present[addr]) begin
                  r.evicted = allocate_line(addr, wdata);
                  r.status  = ST_FILL;
               end else begin
                  word_store[addr]   = wdata;
                  word_present[addr] = 1'b1;
                  r.status           = ST_MEM;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         limit_setting = LIMIT_RESET;
         drop_lines();
         foreach (word_present[i]) begin
            word_present[i] = 1'b0;
            word_store[i]   = '0;
         end
         expected_responses.delete();
      end else begin
         // compare before pushing so a response never matches its own request
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response: got data %h status %0d evicted %b",
                        $time, rsp_read_data, rsp_status, rsp_evicted);
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_read_data !== want.read_data || rsp_status !== want.status ||
                   rsp_evicted !== want.evicted) begin
                  $display("%0t: response mismatch: expected data %h status %0d evicted %b,",
                           $time, want.read_data, want.status, want.evicted);
                  $display("%0t:    got data %h status %0d evicted %b",
                           $time, rsp_read_data, rsp_status, rsp_evicted);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            limit_setting = csr_cache_limit;
            drop_lines();
         end
         if (req_valid && req_ready)
            expected_responses.push_back(predict_access(kind_type'(req_kind),
                                                        req_address, req_write_data));
      end
      failures <= fail_count;
      pending  <= expected_responses.size();
   end

endmodule

// ----- tb/assoc_cache_fifo_writeback_test.sv -----
// Stimulus, clock, reset and verdict for the write-back cache test.
`timescale 1ns / 1ps

module assoc_cache_fifo_writeback_test;
   import acfw_pkg::*;

   localparam int ADDR_BITS   = $clog2(MEM_WORDS_DEF);
   localparam int DATA_BITS   = DATA_BITS_DEF;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 123;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [KIND_BITS-1:0]    req_kind = '0;
   logic [ADDR_BITS-1:0]    req_address = '0;
   logic [DATA_BITS-1:0]    req_write_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DATA_BITS-1:0]    rsp_read_data;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic                    rsp_evicted;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [LIMIT_BITS-1:0]   csr_cache_limit = LIMIT_RESET;

   int  failures;
   int  responses_pending;
   bit  quiet = 1'b0;
   bit  hold_rsp = 1'b0;
   logic [ADDR_BITS-1:0] addr_pool [10];

   always #5 clock = ~clock;

   assoc_cache_fifo_writeback dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .rsp_evicted     (rsp_evicted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_cache_limit (csr_cache_limit)
   );

   acfw_response_check response_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .rsp_evicted     (rsp_evicted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_cache_limit (csr_cache_limit),
      .failures        (failures),
      .pending         (responses_pending)
   );

   // Offer one request after a random gap; return at the edge that takes it.
   task automatic send_request(input kind_type kind, input logic [ADDR_BITS-1:0] addr,
                               input logic [DATA_BITS-1:0] data);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      for (int i = 0; i < gap; i++) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_address    <= addr;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold until every response has been taken.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (responses_pending == 0);
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_cache_limit <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : receiver
      int stall;
      wait (!reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (hold_rsp) begin
            stall    = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         @(negedge clock);
         for (int i = 0; i < stall; i++) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int r;
      logic [LIMIT_BITS-1:0] limit_value;
      logic [ADDR_BITS-1:0]  addr;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: limit at reset value 5
      send_request(KIND_READ,  6'd0,  32'h0000_0000);   // empty word, not found
      send_request(KIND_WRITE, 6'd0,  32'h0000_0000);   // straight to memory
      send_request(KIND_WRITE, 6'd63, 32'hFFFF_FFFF);
      send_request(KIND_READ,  6'd63, 32'h0000_0000);   // fill
      send_request(KIND_READ,  6'd63, 32'hFFFF_FFFF);   // hit
      send_request(KIND_WRITE, 6'd63, 32'h0000_0000);   // write hit in place
      send_request(KIND_WRITE, 6'd0,  32'h1234_5678);   // write allocation
      send_request(KIND_WRITE, 6'd10, 32'hA5A5_A5A5);
      send_request(KIND_WRITE, 6'd11, 32'h5A5A_5A5A);
      send_request(KIND_WRITE, 6'd12, 32'h8000_0001);
      send_request(KIND_WRITE, 6'd13, 32'h7FFF_FFFE);
      send_request(KIND_READ,  6'd10, 32'h0);
      send_request(KIND_READ,  6'd11, 32'h0);
      send_request(KIND_READ,  6'd12, 32'h0);           // cache now full
      send_request(KIND_READ,  6'd13, 32'h0);           // evicts the oldest line
      send_request(KIND_CLEAR_MEM, 6'd63, 32'hFFFF_FFFF);
      send_request(KIND_READ,  6'd0,  32'h0);           // cached line survives
      send_request(KIND_READ,  6'd63, 32'h0);           // gone from memory
      send_request(KIND_WRITE, 6'd40, 32'hDEAD_BEEF);
      send_request(KIND_READ,  6'd40, 32'h0);           // eviction refills memory
      send_request(KIND_READ,  6'd0,  32'h0);
      send_request(KIND_CLEAR_CACHE, 6'd21, 32'h0);
      send_request(KIND_READ,  6'd13, 32'h0);
      send_request(KIND_READ,  6'd40, 32'h0);
      send_request(KIND_WRITE, 6'd13, 32'h0000_FFFF);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: limit_value = 4'd0;
            1: limit_value = 4'd1;
            2: limit_value = 4'd8;
            3: limit_value = 4'd15;
            4: limit_value = LIMIT_RESET;
            default: limit_value = LIMIT_BITS'($urandom_range(0, 15));
         endcase
         write_limit(limit_value);
         quiet = (phase == 3 || phase == 7);
         // long receiver stall while the sender keeps pushing
         if (phase == 3)
            hold_rsp = 1'b1;
         foreach (addr_pool[i])
            addr_pool[i] = ADDR_BITS'($urandom_range(0, MEM_WORDS_DEF - 1));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85)
               addr = addr_pool[$urandom_range(0, 9)];
            else
               addr = ADDR_BITS'($urandom_range(0, MEM_WORDS_DEF - 1));
            if (r < 2)
               send_request(KIND_CLEAR_CACHE, addr, $urandom);
            else if (r < 4)
               send_request(KIND_CLEAR_MEM, addr, $urandom);
            else if (r < 55)
               send_request(KIND_READ, addr, $urandom);
            else
               send_request(KIND_WRITE, addr, $urandom);
            if ($urandom_range(0, 99) == 0)
               drain();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (failures == 0 && responses_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
